// ===== rtl/core/lcs_pkg.sv =====
// lcs_pkg: shared types and constants for the longest common subsequence block
// used by lcs_cell and longest_common_subsequence_length; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

  // fixed port widths
  localparam int CMD_W       = 2;
  localparam int SYM_IN_W    = 8;
  localparam int LEN_OUT_W   = 9;
  localparam int LEN_OUT_MAX = 511;

  // parameter defaults
  localparam int DEF_MAX_LEN     = 256;
  localparam int DEF_SYMBOL_BITS = 8;

  // command codes on in_cmd
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STREAM = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // kind of token moving down the cell chain
  typedef enum logic [1:0] {
    TOK_NONE   = 2'd0,
    TOK_CHAR   = 2'd1,
    TOK_FINISH = 2'd2,
    TOK_CLEAR  = 2'd3
  } tok_kind_t;

  // control part of a token
  typedef struct packed {
    tok_kind_t kind;
    logic      ovf;    // overflow flag captured when the finish was issued
    logic      empty;  // finish issued with an empty first string
  } tok_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/longest_common_subsequence_length.sv =====
// longest_common_subsequence_length: top level, command decode and a chain of lcs_cell
// depends on lcs_pkg and lcs_cell
`timescale 1ns / 1ps
`default_nettype none

// Length of the longest common subsequence of two symbol strings.
// Input: a transaction is taken at a rising edge with start high and busy low.
//   in_cmd load (0) appends in_symbol to the first string, or drops it and
//   sets overflow when MAX_LEN symbols are stored; stream (1) feeds one
//   symbol of the second string; finish (2) reports; clear (3) empties all.
//   Load and finish also restart the second string.
// The first string sits in a row of MAX_LEN cells, one symbol each. Every
// command enters the chain as a token and moves one cell per cycle. Load,
// stream and clear are taken every cycle while busy is low; after a finish
// busy stays high until the token reaches its report cell, and no command
// is taken meanwhile.
// Output: a finish yields one result on out_lcs_length / out_overflow,
//   marked by out_strobe for one cycle and registered from the report of
//   the cell holding the last stored symbol (cell 0, reporting zero, for
//   an empty first string). The receiver cannot stall, nothing waits on it.
// Reset (synchronous, rst_n low) empties the first string, zeroes all match
// lengths and the overflow flag, and drops tokens in flight.
module longest_common_subsequence_length #(
  parameter int MAX_LEN     = lcs_pkg::DEF_MAX_LEN,
  parameter int SYMBOL_BITS = lcs_pkg::DEF_SYMBOL_BITS
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire  [lcs_pkg::CMD_W-1:0]      in_cmd,
  input  wire  [lcs_pkg::SYM_IN_W-1:0]   in_symbol,
  output logic                           out_strobe,
  output logic [lcs_pkg::LEN_OUT_W-1:0]  out_lcs_length,
  output logic                           out_overflow
);

  import lcs_pkg::*;

  localparam int ROW_W = $clog2(MAX_LEN + 1);
  localparam int FL_W  = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int EXT_W = (ROW_W > LEN_OUT_W) ? ROW_W : LEN_OUT_W;

  logic                   accept;
  logic [15:0]            sym_ext;
  logic [SYMBOL_BITS-1:0] sym;
  logic [FL_W-1:0]        first_length_r, first_length_nxt;
  logic                   overflow_r, overflow_nxt;
  logic                   fin_pend_r, fin_pend_nxt;
  logic                   wr_en;
  tok_ctrl_t              head_ctrl;
  logic [IDX_W-1:0]       head_target;

  // chain links, link i feeds cell i
  tok_ctrl_t              ctrl_a   [MAX_LEN];
  logic [SYMBOL_BITS-1:0] sym_a    [MAX_LEN];
  logic [ROW_W-1:0]       left_a   [MAX_LEN];
  logic [ROW_W-1:0]       diag_a   [MAX_LEN];
  logic [IDX_W-1:0]       target_a [MAX_LEN];

  logic [MAX_LEN-1:0]     hit_vec;
  logic [ROW_W-1:0]       hv_a     [MAX_LEN];
  logic [MAX_LEN-1:0]     ho_vec;

  logic [ROW_W-1:0]       hit_value;
  logic                   hit_ovf;
  logic [EXT_W-1:0]       hit_ext;

  logic                   out_strobe_r;
  logic [LEN_OUT_W-1:0]   out_len_r;
  logic                   out_ovf_r;

  // hold off commands while a finish token is still on its way
  assign busy   = fin_pend_r;
  assign accept = start && !busy;

  // finish in flight until its report cell is reached
  always_comb begin
    fin_pend_nxt = fin_pend_r;
    if (|hit_vec) begin
      fin_pend_nxt = 1'b0;
    end else if (accept && (cmd_t'(in_cmd) == CMD_FINISH)) begin
      fin_pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_pend_r <= 1'b0;
    end else begin
      fin_pend_r <= fin_pend_nxt;
    end
  end

  // only the low SYMBOL_BITS bits take part in comparisons
  assign sym_ext = 16'(in_symbol);
  assign sym     = sym_ext[SYMBOL_BITS-1:0];

  // command decode: token for cell 0 and first-string bookkeeping
  always_comb begin
    head_ctrl        = '{kind: TOK_NONE, ovf: overflow_r, empty: 1'b0};
    head_target      = '0;
    first_length_nxt = first_length_r;
    overflow_nxt     = overflow_r;
    wr_en            = 1'b0;
    if (accept) begin
      case (cmd_t'(in_cmd))
        CMD_LOAD: begin
          head_ctrl.kind = TOK_CLEAR;
          if (first_length_r < FL_W'(MAX_LEN)) begin
            wr_en            = 1'b1;
            first_length_nxt = first_length_r + FL_W'(1);
          end else begin
            overflow_nxt = 1'b1;
          end
        end
        CMD_STREAM: begin
          head_ctrl.kind = TOK_CHAR;
        end
        CMD_FINISH: begin
          head_ctrl.kind = TOK_FINISH;
          if (first_length_r == '0) begin
            head_ctrl.empty = 1'b1;
          end else begin
            head_target = IDX_W'(first_length_r - FL_W'(1));
          end
        end
        CMD_CLEAR: begin
          head_ctrl.kind   = TOK_CLEAR;
          first_length_nxt = '0;
          overflow_nxt     = 1'b0;
        end
        default: begin
          head_ctrl.kind = TOK_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_length_r <= '0;
      overflow_r     <= 1'b0;
    end else begin
      first_length_r <= first_length_nxt;
      overflow_r     <= overflow_nxt;
    end
  end

  // head of the chain: row zero is all zeros
  assign ctrl_a[0]   = head_ctrl;
  assign sym_a[0]    = sym;
  assign left_a[0]   = '0;
  assign diag_a[0]   = '0;
  assign target_a[0] = head_target;

  // row of cells
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic cell_wr;
    assign cell_wr = wr_en && (first_length_r[IDX_W-1:0] == IDX_W'(i));
    if (i < MAX_LEN - 1) begin : g_mid
      lcs_cell #(
        .INDEX      (i),
        .SYMBOL_BITS(SYMBOL_BITS),
        .ROW_W      (ROW_W),
        .IDX_W      (IDX_W)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cell_wr),
        .wr_sym    (sym),
        .in_ctrl   (ctrl_a[i]),
        .in_sym    (sym_a[i]),
        .in_left   (left_a[i]),
        .in_diag   (diag_a[i]),
        .in_target (target_a[i]),
        .out_ctrl  (ctrl_a[i+1]),
        .out_sym   (sym_a[i+1]),
        .out_left  (left_a[i+1]),
        .out_diag  (diag_a[i+1]),
        .out_target(target_a[i+1]),
        .hit       (hit_vec[i]),
        .hit_value (hv_a[i]),
        .hit_ovf   (ho_vec[i])
      );
    end else begin : g_last
      lcs_cell #(
        .INDEX      (i),
        .SYMBOL_BITS(SYMBOL_BITS),
        .ROW_W      (ROW_W),
        .IDX_W      (IDX_W)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cell_wr),
        .wr_sym    (sym),
        .in_ctrl   (ctrl_a[i]),
        .in_sym    (sym_a[i]),
        .in_left   (left_a[i]),
        .in_diag   (diag_a[i]),
        .in_target (target_a[i]),
        .out_ctrl  (),
        .out_sym   (),
        .out_left  (),
        .out_diag  (),
        .out_target(),
        .hit       (hit_vec[i]),
        .hit_value (hv_a[i]),
        .hit_ovf   (ho_vec[i])
      );
    end
  end

  // gather the report of the one cell that a finish token hits
  always_comb begin
    hit_value = '0;
    hit_ovf   = 1'b0;
    for (int k = 0; k < MAX_LEN; k++) begin
      hit_value = hit_value | (hit_vec[k] ? hv_a[k] : '0);
      hit_ovf   = hit_ovf | (hit_vec[k] & ho_vec[k]);
    end
  end

  // extend to a common width before saturating to the output width
  assign hit_ext = EXT_W'(hit_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= |hit_vec;
    end
  end

  always_ff @(posedge clk) begin
    out_len_r <= (hit_ext > EXT_W'(LEN_OUT_MAX)) ? LEN_OUT_W'(LEN_OUT_MAX)
                                                  : hit_ext[LEN_OUT_W-1:0];
    out_ovf_r <= hit_ovf;
  end

  assign out_strobe     = out_strobe_r;
  assign out_lcs_length = out_len_r;
  assign out_overflow   = out_ovf_r;

`ifndef ASSERT_OFF
  // at most one cell reports per cycle
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
    else $error("more than one cell hit by finish tokens");

  // stored length never exceeds the chain
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    first_length_r <= FL_W'(MAX_LEN))
    else $error("first string length beyond chain depth");

  // clear empties the first string and the overflow flag
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_CLEAR)) |=> (first_length_r == '0) && !overflow_r)
    else $error("clear did not empty the first string");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe after reset");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lcs_cell.sv =====
// lcs_cell: one systolic cell holding a first-string character and its match length
// depends on lcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcs_cell #(
  parameter int INDEX       = 0,
  parameter int SYMBOL_BITS = lcs_pkg::DEF_SYMBOL_BITS,
  parameter int ROW_W       = 9,
  parameter int IDX_W       = 8
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // character write
  input  wire                    wr_en,
  input  wire  [SYMBOL_BITS-1:0] wr_sym,
  // token from the left neighbor
  input  wire  lcs_pkg::tok_ctrl_t in_ctrl,
  input  wire  [SYMBOL_BITS-1:0] in_sym,
  input  wire  [ROW_W-1:0]       in_left,
  input  wire  [ROW_W-1:0]       in_diag,
  input  wire  [IDX_W-1:0]       in_target,
  // token to the right neighbor
  output lcs_pkg::tok_ctrl_t     out_ctrl,
  output logic [SYMBOL_BITS-1:0] out_sym,
  output logic [ROW_W-1:0]       out_left,
  output logic [ROW_W-1:0]       out_diag,
  output logic [IDX_W-1:0]       out_target,
  // finish report
  output logic                   hit,
  output logic [ROW_W-1:0]       hit_value,
  output logic                   hit_ovf
);

  import lcs_pkg::*;

  logic [SYMBOL_BITS-1:0] ch_r;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [ROW_W-1:0]       cand;
  tok_ctrl_t              ctrl_r;
  logic [SYMBOL_BITS-1:0] sym_r;
  logic [ROW_W-1:0]       left_r, diag_r;
  logic [IDX_W-1:0]       target_r;

  // recurrence: diagonal plus one on a match, else larger of left and up
  always_comb begin
    if (ch_r == in_sym) begin
      cand = in_diag + ROW_W'(1);
    end else begin
      cand = (in_left > row_r) ? in_left : row_r;
    end
  end

  // row update per token kind
  always_comb begin
    case (in_ctrl.kind)
      TOK_CHAR:   row_nxt = cand;
      TOK_FINISH: row_nxt = '0;
      TOK_CLEAR:  row_nxt = '0;
      default:    row_nxt = row_r;
    endcase
  end

  // finish report taken before this cell clears
  assign hit       = (in_ctrl.kind == TOK_FINISH) && (in_target == IDX_W'(INDEX));
  assign hit_value = in_ctrl.empty ? '0 : row_r;
  assign hit_ovf   = in_ctrl.ovf;

  // stored character
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ch_r <= wr_sym;
    end
  end

  // match length and token control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      ctrl_r <= '{kind: TOK_NONE, ovf: 1'b0, empty: 1'b0};
    end else begin
      row_r  <= row_nxt;
      ctrl_r <= in_ctrl;
    end
  end

  // token payload toward the next cell
  always_ff @(posedge clk) begin
    sym_r    <= in_sym;
    left_r   <= cand;
    diag_r   <= row_r;
    target_r <= in_target;
  end

  assign out_ctrl   = ctrl_r;
  assign out_sym    = sym_r;
  assign out_left   = left_r;
  assign out_diag   = diag_r;
  assign out_target = target_r;

endmodule

`default_nettype wire
